// ===== rtl/spp_pkg.sv =====
// spp_pkg: sizes, codes, state encoding and command struct for sorted_port_set
// no dependencies; compiled before the interfaces and every module
package spp_pkg;

    localparam int CAPACITY  = 32;
    localparam int KEY_W     = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int OUT_CNT_W = 6;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic compare;
        logic commit;
    } spp_cmd_t;

endpackage

// ===== rtl/spp_if.sv =====
// spp_op_if and spp_res_if: valid/ready channels of sorted_port_set
// depends on spp_pkg for the field widths
interface spp_op_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [spp_pkg::KEY_W-1:0] port_key;

    modport source (output valid, output func, output port_key, input ready);
    modport sink   (input valid, input func, input port_key, output ready);
endinterface

interface spp_res_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [spp_pkg::OUT_CNT_W-1:0] entry_count;
    logic [spp_pkg::KEY_W-1:0]     first_port;
    logic [spp_pkg::KEY_W-1:0]     last_port;

    modport source (output valid, output ok, output entry_count, output first_port,
                    output last_port, input ready);
    modport sink   (input valid, input ok, input entry_count, input first_port,
                    input last_port, output ready);
endinterface

// ===== rtl/spp_ctrl.sv =====
// spp_ctrl: sequencer of sorted_port_set (capture, compare, commit) and result valid
// depends on spp_pkg
module spp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_ready,
    output logic              res_valid,
    input  logic              res_ready,
    output spp_pkg::spp_cmd_t cmd
);
    import spp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   out_free;

    // result register can take a new beat
    assign out_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                    state_next = S_CMP;
            end
            S_CMP:
                state_next = S_UPD;
            S_UPD:
            begin
                if (out_free)
                    state_next = op_valid ? S_CMP : S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.compare = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
                op_ready = 1'b1;
            S_CMP:
                cmd.compare = 1'b1;
            S_UPD:
            begin
                cmd.commit = out_free;
                op_ready   = out_free;
            end
            default:
                op_ready = 1'b0;
        endcase
        cmd.capture = op_ready && op_valid;
    end

    assign res_valid_next = cmd.commit ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    assign res_valid      = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    a_commit_only_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> state_reg == S_UPD)
        else $error("commit outside update state");

    a_valid_rises_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(cmd.commit))
        else $error("result valid without a commit");

    a_compare_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_CMP && cmd.compare)
        else $error("captured beat not compared next cycle");

    a_no_commit_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |-> !cmd.commit)
        else $error("commit over an untaken result");

endmodule

// ===== rtl/spp_dp.sv =====
// spp_dp: row of compare-and-shift key cells, held count, low/high keys, ok flag
// depends on spp_pkg; driven by spp_ctrl commands
module spp_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spp_pkg::spp_cmd_t                cmd,
    input  logic                             func,
    input  logic [spp_pkg::KEY_W-1:0]        port_key,
    output logic                             ok,
    output logic [spp_pkg::OUT_CNT_W-1:0]    entry_count,
    output logic [spp_pkg::KEY_W-1:0]        first_port,
    output logic [spp_pkg::KEY_W-1:0]        last_port
);
    import spp_pkg::*;

    key_t                cells_reg [CAPACITY];
    key_t                cells_next [CAPACITY];
    key_t                prev_cell [CAPACITY];
    key_t                succ_cell [CAPACITY];
    cnt_t                count_reg;
    cnt_t                count_next;
    key_t                low_reg;
    key_t                low_next;
    key_t                high_reg;
    key_t                high_next;
    logic                ok_reg;
    logic                ok_next;
    func_t               func_reg;
    key_t                key_reg;
    logic [CAPACITY-1:0] lt_reg;
    logic [CAPACITY-1:0] lt_next;
    logic [CAPACITY-1:0] eq_vec;
    logic                hit_reg;
    key_t                penult_reg;
    logic                full;
    logic                empty;
    logic                ins_ok;
    logic                rem_ok;

    // neighbour taps of each cell
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_tap
            if (g == 0)
            begin : g_first
                assign prev_cell[g] = key_reg;
            end
            else
            begin : g_mid
                assign prev_cell[g] = cells_reg[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign succ_cell[g] = cells_reg[g];
            end
            else
            begin : g_inner
                assign succ_cell[g] = cells_reg[g+1];
            end
            assign lt_next[g] = (cnt_t'(g) < count_reg) && (cells_reg[g] < key_reg);
            assign eq_vec[g]  = (cnt_t'(g) < count_reg) && (cells_reg[g] == key_reg);
        end
    endgenerate

    assign full   = count_reg == cnt_t'(CAPACITY);
    assign empty  = count_reg == '0;
    assign ins_ok = !hit_reg && !full;
    assign rem_ok = hit_reg;

    always_comb
    begin
        cells_next = cells_reg;
        count_next = count_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        ok_next    = ok_reg;
        if (cmd.commit)
        begin
            if (func_reg == FUNC_INSERT)
            begin
                ok_next = ins_ok;
                if (ins_ok)
                begin
                    // cells at or past the slot move up one, the slot takes the key
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (!lt_reg[i])
                            cells_next[i] = (i == 0 || lt_reg[IDX_W'(i) - 1'b1])
                                            ? key_reg : prev_cell[i];
                    end
                    count_next = count_reg + cnt_t'(1);
                    low_next   = (empty || key_reg < low_reg) ? key_reg : low_reg;
                    high_next  = (empty || key_reg > high_reg) ? key_reg : high_reg;
                end
            end
            else
            begin
                ok_next = rem_ok;
                if (rem_ok)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (!lt_reg[i])
                            cells_next[i] = succ_cell[i];
                    end
                    count_next = count_reg - cnt_t'(1);
                    // last key gone: low and high stay as they were
                    if (count_reg > cnt_t'(1))
                    begin
                        low_next  = lt_reg[0] ? low_reg : cells_reg[1];
                        high_next = (key_reg == high_reg) ? penult_reg : high_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
        if (cmd.capture)
        begin
            func_reg <= func_t'(func);
            key_reg  <= port_key;
        end
        if (cmd.compare)
        begin
            lt_reg     <= lt_next;
            hit_reg    <= |eq_vec;
            penult_reg <= cells_reg[IDX_W'(count_reg - cnt_t'(2))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            ok_reg    <= ok_next;
        end
    end

    assign ok          = ok_reg;
    assign entry_count = OUT_CNT_W'(count_reg);
    assign first_port  = low_reg;
    assign last_port   = high_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(CAPACITY))
        else $error("held count past capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && func_reg == FUNC_INSERT && ins_ok
        |=> count_reg == $past(count_reg) + cnt_t'(1))
        else $error("accepted insert did not grow the set");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && func_reg == FUNC_REMOVE && rem_ok
        |=> count_reg == $past(count_reg) - cnt_t'(1))
        else $error("accepted remove did not shrink the set");

    a_ends_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> cells_reg[0] == low_reg && low_reg <= high_reg)
        else $error("low key out of step with the first cell");

endmodule

// ===== rtl/sorted_port_set.sv =====
// sorted_port_set: ascending set of distinct port keys with insert and remove
// steps: capture at the accepting edge, then compare, then commit; result valid is registered
// a new beat is taken only when idle or in the commit step, after the compare then shift of the cell row
// a result left untaken holds the next beat in the commit step until it goes
// reset (rst_n, async, active low): set empty, low and high keys zero, no result pending
module sorted_port_set (
    input  logic      clk,
    input  logic      rst_n,
    spp_op_if.sink    op,
    spp_res_if.source res
);
    import spp_pkg::*;

    spp_cmd_t cmd;

    spp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op.valid),
        .op_ready  (op.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cmd       (cmd)
    );

    spp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (op.func),
        .port_key    (op.port_key),
        .ok          (res.ok),
        .entry_count (res.entry_count),
        .first_port  (res.first_port),
        .last_port   (res.last_port)
    );

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for sorted_port_set, directed table then biased random ops
// depends on spp_pkg and the spp_op_if / spp_res_if interfaces from the rtl folder
// results are compared field by field against an in-bench model of the sorted key store
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spp_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ROUNDS = 10;
    localparam int OPS_PER_ROUND = 50;
    localparam int POOL_SIZE = 48;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        logic                 ok;
        logic [OUT_CNT_W-1:0] entry_count;
        key_t                 first_port;
        key_t                 last_port;
    } port_result_t;

    typedef struct packed {
        func_t        func;
        key_t         port_key;
        logic         typed;
        port_result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    spp_op_if  op_if ();
    spp_res_if res_if ();

    sorted_port_set u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_if),
        .res   (res_if)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // model of the key store, updated in the driver process at each accepted beat
    key_t        held_keys [CAPACITY];
    int unsigned held_n;
    key_t        low_key;
    key_t        high_key;

    port_result_t expected_results [$];
    key_t         key_pool [POOL_SIZE];
    stim_row_t    directed_rows [DIRECTED_ROWS];

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned results_checked = 0;
    int unsigned inserts_sent = 0;
    int unsigned removes_sent = 0;
    int unsigned ops_refused = 0;
    int unsigned full_refusals = 0;
    int unsigned empty_removals = 0;
    bit          quiet = 1'b0;

    function automatic port_result_t apply_port_op(input func_t f, input key_t k);
        port_result_t r;
        int unsigned  p;
        int unsigned  i;
        logic         ok;
        p = 0;
        ok = 1'b0;
        while (p < held_n && held_keys[p] < k)
            p++;
        if (f == FUNC_INSERT)
        begin
            inserts_sent++;
            if (held_n >= CAPACITY && !(p < held_n && held_keys[p] == k))
                full_refusals++;
            if (!(p < held_n && held_keys[p] == k) && held_n < CAPACITY)
            begin
                for (i = held_n; i > p; i--)
                    held_keys[i] = held_keys[i-1];
                held_keys[p] = k;
                held_n++;
                low_key = held_keys[0];
                high_key = held_keys[held_n-1];
                ok = 1'b1;
            end
        end
        else
        begin
            removes_sent++;
            if (p < held_n && held_keys[p] == k)
            begin
                for (i = p; i + 1 < held_n; i++)
                    held_keys[i] = held_keys[i+1];
                held_n--;
                // low and high keys stay put once the store is emptied
                if (held_n > 0)
                begin
                    low_key = held_keys[0];
                    high_key = held_keys[held_n-1];
                end
                else
                    empty_removals++;
                ok = 1'b1;
            end
        end
        if (!ok)
            ops_refused++;
        r.ok = ok;
        r.entry_count = held_n[OUT_CNT_W-1:0];
        r.first_port = low_key;
        r.last_port = high_key;
        return r;
    endfunction

    function automatic int unsigned idle_len();
        if ($urandom_range(99) < 88)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic key_t pick_key(input func_t f);
        int unsigned r;
        r = $urandom_range(99);
        if (f == FUNC_REMOVE && held_n > 0 && r < 60)
            return held_keys[$urandom_range(held_n - 1)];
        if (f == FUNC_INSERT && held_n > 0 && r < 10)
            return held_keys[$urandom_range(held_n - 1)];
        if (r < 85)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return key_t'($urandom_range(16'hFFFF));
    endfunction

    // called at a rising edge; returns at the rising edge that took the beat
    task automatic send_op(input func_t f, input key_t k, input logic typed,
                           input port_result_t want);
        int unsigned  gap;
        logic         took;
        port_result_t predicted;
        gap = (!quiet && $urandom_range(99) < 40) ? idle_len() : 0;
        if (gap > 0)
        begin
            op_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_if.valid <= 1'b1;
        op_if.func <= f;
        op_if.port_key <= k;
        forever
        begin
            @(negedge clk);
            took = op_if.ready;
            @(posedge clk);
            if (took)
                break;
        end
        predicted = apply_port_op(f, k);
        expected_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random back-pressure, compare each taken beat with the oldest expectation
    initial
    begin
        int unsigned  stall_left;
        logic         took;
        port_result_t got;
        port_result_t want;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            took = res_if.valid && res_if.ready;
            got.ok = res_if.ok;
            got.entry_count = res_if.entry_count;
            got.first_port = res_if.first_port;
            got.last_port = res_if.last_port;
            @(posedge clk);
            if (took)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: ok %0d count %0d first %h last %h",
                           got.ok, got.entry_count, got.first_port, got.last_port);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.ok !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, got.ok);
                        error_count++;
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        error_count++;
                    end
                    if (got.first_port !== want.first_port)
                    begin
                        $error("first_port: expected %h, got %h", want.first_port,
                               got.first_port);
                        error_count++;
                    end
                    if (got.last_port !== want.last_port)
                    begin
                        $error("last_port: expected %h, got %h", want.last_port,
                               got.last_port);
                        error_count++;
                    end
                end
            end
            if (!quiet && stall_left == 0 && $urandom_range(99) < 30)
                stall_left = idle_len();
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int          insert_pct [ROUNDS];
        int unsigned i;
        int unsigned j;
        func_t       f;
        rst_n = 1'b0;
        op_if.valid = 1'b0;
        op_if.func = FUNC_INSERT;
        op_if.port_key = '0;
        held_n = 0;
        low_key = '0;
        high_key = '0;
        foreach (held_keys[n])
            held_keys[n] = '0;

        // ok, entry_count, first_port, last_port typed only where obvious
        directed_rows = '{
            '{FUNC_REMOVE, 16'h0000, 1'b1, '{1'b0, 6'd0, 16'h0000, 16'h0000}},
            '{FUNC_INSERT, 16'hFFFF, 1'b1, '{1'b1, 6'd1, 16'hFFFF, 16'hFFFF}},
            '{FUNC_INSERT, 16'h0000, 1'b1, '{1'b1, 6'd2, 16'h0000, 16'hFFFF}},
            '{FUNC_INSERT, 16'h0000, 1'b1, '{1'b0, 6'd2, 16'h0000, 16'hFFFF}},
            '{FUNC_REMOVE, 16'h1234, 1'b1, '{1'b0, 6'd2, 16'h0000, 16'hFFFF}},
            '{FUNC_REMOVE, 16'h0000, 1'b1, '{1'b1, 6'd1, 16'hFFFF, 16'hFFFF}},
            '{FUNC_REMOVE, 16'hFFFF, 1'b1, '{1'b1, 6'd0, 16'hFFFF, 16'hFFFF}},
            '{FUNC_REMOVE, 16'hFFFF, 1'b1, '{1'b0, 6'd0, 16'hFFFF, 16'hFFFF}},
            '{FUNC_INSERT, 16'h8000, 1'b1, '{1'b1, 6'd1, 16'h8000, 16'h8000}},
            '{FUNC_INSERT, 16'h7FFF, 1'b0, '0},
            '{FUNC_INSERT, 16'h0001, 1'b0, '0},
            '{FUNC_INSERT, 16'hFFFE, 1'b0, '0},
            '{FUNC_INSERT, 16'hAAAA, 1'b0, '0},
            '{FUNC_INSERT, 16'h5555, 1'b0, '0},
            '{FUNC_REMOVE, 16'h8000, 1'b0, '0},
            '{FUNC_REMOVE, 16'h8001, 1'b0, '0},
            '{FUNC_REMOVE, 16'h0001, 1'b0, '0},
            '{FUNC_REMOVE, 16'hFFFE, 1'b0, '0},
            '{FUNC_INSERT, 16'h0000, 1'b0, '0},
            '{FUNC_INSERT, 16'hFFFF, 1'b0, '0},
            '{FUNC_REMOVE, 16'h5555, 1'b0, '0},
            '{FUNC_REMOVE, 16'h7FFF, 1'b0, '0}
        };
        // fill, mix and drain phases so the store goes full and empty several times
        insert_pct = '{85, 50, 15, 90, 50, 10, 85, 60, 20, 50};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_op(directed_rows[i].func, directed_rows[i].port_key,
                    directed_rows[i].typed, directed_rows[i].want);

        for (i = 0; i < ROUNDS; i++)
        begin
            quiet = (i == 3 || i == 7);
            key_pool[0] = 16'h0000;
            key_pool[1] = 16'hFFFF;
            key_pool[2] = 16'h0001;
            key_pool[3] = 16'hFFFE;
            for (j = 4; j < POOL_SIZE; j++)
                key_pool[j] = key_t'($urandom_range(16'hFFFF));
            for (j = 0; j < OPS_PER_ROUND; j++)
            begin
                f = ($urandom_range(99) < insert_pct[i]) ? FUNC_INSERT : FUNC_REMOVE;
                send_op(f, pick_key(f), 1'b0, '0);
            end
        end
        quiet = 1'b0;
        op_if.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d inserts and %0d removes sent, %0d results checked, %0d refused",
                 inserts_sent, removes_sent, results_checked, ops_refused);
        $display("%0d inserts refused on a full store, store emptied by removal %0d times",
                 full_refusals, empty_removals);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
